// ----- sv/frame_header_decoder_crc_check_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the frame header decoder
// Concurrent check wrappers; they compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef FRAME_HEADER_DECODER_CRC_CHECK_UNIT_MACROS_SVH
`define FRAME_HEADER_DECODER_CRC_CHECK_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define FHD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fhd assertion failed");
// next-cycle implication
`define FHD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fhd assertion failed");
`else
`define FHD_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define FHD_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/fhd_pkg.sv -----
// ---------------------------------------------------------------------------
// fhd_pkg
// Shared constants, types and CRC byte-update functions.
// ---------------------------------------------------------------------------
package fhd_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W           = (POS_W > 12) ? POS_W : 12;
    localparam int MIN_FRAME_BYTES = 16;
    localparam int TRAILER_BYTES   = 3;
    localparam int TID_W           = 10;
    localparam int OFF_W           = 11;
    localparam int LEN_W           = 12;
    localparam int OUT_BITS        = 2 + 8 + 8 + 32 + 8 + 48 + OFF_W + LEN_W + 1 + 1;
    localparam int OUT_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [7:0]  CRC8_POLY  = 8'h07;
    localparam logic [7:0]  CRC8_INIT  = 8'h00;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LONG  = 2'd2
    } status_t;

    // header fields and length checks for the word being processed
    typedef struct packed {
        status_t            status;
        logic [7:0]         command;
        logic [7:0]         route_total;
        logic [31:0]        source_id;
        logic [7:0]         transaction_id;
        logic [47:0]        timestamp;
        logic [OFF_W-1:0]   body_start;
        logic [LEN_W-1:0]   body_length;
    } hdr_result_t;

    // CRC datapath control from the header tracker
    typedef struct packed {
        logic step;       // a word is processed this cycle
        logic frame_end;  // that word closes the frame
        logic shift;      // word is within the size limit
        logic feed;       // oldest delay byte leaves toward the CRCs
        logic body_feed;  // and it belongs to the body
    } crc_ctl_t;

    typedef struct packed {
        logic body_ok;
        logic frame_ok;
    } crc_flags_t;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/fhd_hdr_capture.sv -----
// ---------------------------------------------------------------------------
// fhd_hdr_capture
// Byte position, overflow flag and header field capture; length checks.
// ---------------------------------------------------------------------------
`include "frame_header_decoder_crc_check_unit_macros.svh"

module fhd_hdr_capture
    import fhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output crc_ctl_t    crc_ctl,
    output hdr_result_t hdr
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [7:0]       command_reg;
    logic [7:0]       route_reg;
    logic [31:0]      source_reg;
    logic [7:0]       tid_reg;
    logic [47:0]      ts_reg;

    logic             in_range;
    logic [7:0]       route_eff;
    logic [TID_W-1:0] tid_pos;
    logic [OFF_W-1:0] body_at;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] len_c;
    logic [CMP_W-1:0] tid_c;
    logic [CMP_W-1:0] off_c;
    logic [CMP_W-1:0] req_c;
    logic             cap_tid;
    logic             cap_ts;
    logic             cap_src;

    always_comb
    begin
        in_range  = pos_reg < POS_W'(MAX_FRAME_BYTES);
        route_eff = (pos_reg == POS_W'(1)) ? data_byte : route_reg;
        tid_pos   = {route_eff, 2'b00} + TID_W'(2);
        body_at   = OFF_W'(tid_pos) + OFF_W'(7);
        pos_next  = in_range ? (pos_reg + POS_W'(1)) : pos_reg;
        ovf_next  = ovf_reg | ~in_range;

        pos_c = CMP_W'(pos_reg);
        len_c = CMP_W'(pos_next);
        tid_c = CMP_W'(tid_pos);
        off_c = CMP_W'(body_at);
        req_c = tid_c + CMP_W'(10);

        cap_src = (pos_c >= CMP_W'(2)) && (pos_c <= CMP_W'(5));
        cap_tid = (pos_c >= CMP_W'(2)) && (pos_c == tid_c);
        cap_ts  = (pos_c > tid_c) && (pos_c <= tid_c + CMP_W'(6));

        crc_ctl.step      = step;
        crc_ctl.frame_end = last_byte;
        crc_ctl.shift     = in_range;
        crc_ctl.feed      = pos_c >= CMP_W'(3);
        crc_ctl.body_feed = pos_c >= off_c + CMP_W'(TRAILER_BYTES);

        if (ovf_next)
            hdr.status = ST_LONG;
        else if ((len_c < CMP_W'(MIN_FRAME_BYTES)) || (len_c < req_c))
            hdr.status = ST_SHORT;
        else
            hdr.status = ST_OK;
        hdr.command        = command_reg;
        hdr.route_total    = route_reg;
        hdr.source_id      = source_reg;
        hdr.transaction_id = tid_reg;
        hdr.timestamp      = ts_reg;
        hdr.body_start     = body_at;
        hdr.body_length    = LEN_W'(len_c - off_c - CMP_W'(TRAILER_BYTES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    // header fields are overwritten before any good frame reads them
    always_ff @(posedge clk)
    begin
        if (step && in_range)
        begin
            if (pos_reg == '0)
                command_reg <= data_byte;
            if (pos_reg == POS_W'(1))
                route_reg <= data_byte;
            if (cap_src)
                source_reg <= {source_reg[23:0], data_byte};
            if (cap_tid)
                tid_reg <= data_byte;
            if (cap_ts)
                ts_reg <= {ts_reg[39:0], data_byte};
        end
    end

    `FHD_ASSERT_NEXT(a_pos_clear_at_end, clk, rst_n, step && last_byte, pos_reg == '0 && !ovf_reg)
    `FHD_ASSERT_IMPL(a_ovf_at_limit, clk, rst_n, ovf_reg, pos_reg == POS_W'(MAX_FRAME_BYTES))

endmodule

// ----- sv/fhd_crc_unit.sv -----
// ---------------------------------------------------------------------------
// fhd_crc_unit
// Three-byte delay line, running CRC-8/CRC-16 and trailer compare.
// ---------------------------------------------------------------------------
module fhd_crc_unit
    import fhd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  crc_ctl_t   ctl,
    input  logic [7:0] data_byte,
    output crc_flags_t flags
);

    logic [7:0]  delay_reg [3];
    logic [7:0]  body_crc_reg;
    logic [15:0] frame_crc_reg;
    logic [7:0]  body_crc_next;
    logic [15:0] frame_crc_next;
    logic [7:0]  d0_next;
    logic [7:0]  d1_next;
    logic [7:0]  d2_next;

    always_comb
    begin
        body_crc_next  = body_crc_reg;
        frame_crc_next = frame_crc_reg;
        if (ctl.shift && ctl.feed)
        begin
            frame_crc_next = crc16_feed(frame_crc_reg, delay_reg[2]);
            if (ctl.body_feed)
                body_crc_next = crc8_feed(body_crc_reg, delay_reg[2]);
        end
        d0_next = ctl.shift ? data_byte    : delay_reg[0];
        d1_next = ctl.shift ? delay_reg[0] : delay_reg[1];
        d2_next = ctl.shift ? delay_reg[1] : delay_reg[2];

        // trailer: CRC-8 byte, then CRC-16 big-endian
        flags.body_ok  = d2_next == body_crc_next;
        flags.frame_ok = {d1_next, d0_next} == crc16_feed(frame_crc_next, d2_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_crc_reg  <= CRC8_INIT;
            frame_crc_reg <= CRC16_INIT;
        end
        else if (ctl.step)
        begin
            if (ctl.frame_end)
            begin
                body_crc_reg  <= CRC8_INIT;
                frame_crc_reg <= CRC16_INIT;
            end
            else
            begin
                body_crc_reg  <= body_crc_next;
                frame_crc_reg <= frame_crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            delay_reg[0] <= d0_next;
            delay_reg[1] <= d1_next;
            delay_reg[2] <= d2_next;
        end
    end

endmodule

// ----- sv/frame_header_decoder_crc_check_unit.sv -----
// ---------------------------------------------------------------------------
// frame_header_decoder_crc_check_unit
// A last word is accepted into the input register; its result is then loaded
//   into the result register, which drives m_tvalid until the sink takes it.
// Throughput: one word per cycle; words without tlast produce no output. A last
//   word waits only while the result register holds a result not yet taken.
// Reset (rst_n, async, active low) empties both registers and returns the
//   frame tracker to byte 0 with CRC-8 = 0x00 and CRC-16 = 0xFFFF.
// ---------------------------------------------------------------------------
`include "frame_header_decoder_crc_check_unit_macros.svh"

module frame_header_decoder_crc_check_unit
    import fhd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] frame_status, [9:2] command, [17:10] route_total,
    // [49:18] source_id, [57:50] transaction_id, [105:58] timestamp,
    // [116:106] body_start, [128:117] body_length, [129] body_check_ok,
    // [130] frame_check_ok, [135:131] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // Input register: holds one word ahead of the frame tracker.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;

    // Result register: one finished frame result waiting for the sink.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic                   proc_fire;
    crc_ctl_t               crc_ctl;
    hdr_result_t            hdr;
    crc_flags_t             flags;

    // A buffered word moves into the tracker unless it ends a frame and the
    // result register is still occupied by a result the sink has not taken.
    assign proc_fire = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    fhd_hdr_capture u_hdr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc_fire),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .crc_ctl   (crc_ctl),
        .hdr       (hdr)
    );

    fhd_crc_unit u_crc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .data_byte (in_byte_reg),
        .flags     (flags)
    );

    // Error results carry the status alone; every other field is zero.
    always_comb
    begin
        out_data_next = '0;
        out_data_next[1:0] = hdr.status;
        if (hdr.status == ST_OK)
        begin
            out_data_next[OUT_BITS-1:0] = {flags.frame_ok, flags.body_ok,
                                           hdr.body_length, hdr.body_start,
                                           hdr.timestamp, hdr.transaction_id,
                                           hdr.source_id, hdr.route_total,
                                           hdr.command, hdr.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (proc_fire)
                in_valid_reg <= 1'b0;

            if (proc_fire && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc_fire && in_last_reg)
            out_data_reg <= out_data_next;
    end

    `FHD_ASSERT_IMPL(a_error_fields_zero, clk, rst_n, out_valid_reg && out_data_reg[1:0] != ST_OK, out_data_reg[OUT_TDATA_W-1:2] == '0)
    `FHD_ASSERT_IMPL(a_result_from_last, clk, rst_n, $rose(out_valid_reg), $past(proc_fire && in_last_reg))

endmodule
